[design/sctab_pkg.sv]
// Package for the S-curve step ramp table: word types, widths and constants.
// Used by sctab_div and s_curve_step_ramp_table; depends on nothing.
package sctab_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int SPD_W  = 26;          // speed word, steps per second
    localparam int DIV_NW = 46;          // dividend width of the shared divider
    localparam int DIV_DW = 26;          // divisor width of the shared divider

    // Reciprocals for the fixed divisions: x / 60 is (x >> 2) / 15 and
    // x / 2000000 is (x >> 7) / 15625, each taken as a multiply and a shift.
    localparam logic [29:0] RECIP_15    = 30'd572662307;    // ceil(2^33 / 15)
    localparam logic [40:0] RECIP_15625 = 41'd1152921504607; // ceil(2^54 / 15625)

    localparam logic [1:0] CFG_FULL_STEPS = 2'd0;
    localparam logic [1:0] CFG_MICROSTEPS = 2'd1;
    localparam logic [1:0] CFG_MIN_PULSES = 2'd2;

    localparam logic CMD_RAMP = 1'b0;

    typedef struct packed {
        logic        cmd;
        logic [11:0] start_rpm;
        logic [11:0] end_rpm;
        logic [5:0]  ramp_intervals;
        logic [19:0] interval_us;
    } t_cmd;

    typedef struct packed {
        logic [5:0]  level_index;
        logic [31:0] pulses_per_interval;
        logic [15:0] hold_intervals;
        logic [39:0] cumulative_pulses;
        logic        empty_res;
        logic        last;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

endpackage

[design/sctab_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the divisions by a varying divisor.
// Depends on sctab_pkg for the request and response structs.
module sctab_div
    import sctab_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [DIV_DW:0]   n_shift;
    logic              n_ge;

    always_comb begin
        n_shift = {r_rem, r_quo[DIV_NW-1]};
        n_ge    = (n_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_NW-2:0], n_ge};
                r_rem <= n_ge ? DIV_DW'(n_shift - {1'b0, r_dvs}) : n_shift[DIV_DW-1:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

[design/s_curve_step_ramp_table.sv]
// S-curve step ramp table: top level with sequencer and the two table memories.
// Depends on sctab_pkg and sctab_div.
//
// Usage: drive a command word on i_cmd and raise start; the word is taken
// at a rising edge where start is high and busy is low. A command word
// whose cmd bit is set is dropped without any result. Otherwise the block
// builds the speed table in its speed memory, turns it into pulse counts
// kept in the level memory, and then sends one result word per kept level
// (nonzero and unlike the level kept before it) on o_result, each marked
// by o_res_valid for exactly one cycle, with last set on the final one. A
// request that keeps no level gives a single word with empty_res and last set.
// Divisions by a varying divisor share one bit-serial divider; the fixed
// divisions use reciprocal multiplication. busy falls in the cycle that
// carries the last word; the receiver cannot hold results off.
// Reset restores the register defaults (200 full steps, 1 microstep,
// 50 minimum pulses) and idles the sequencer; table contents are not cleared
// and are always written before they are read. Write i_cfg only while idle.
module s_curve_step_ramp_table
    import sctab_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_cmd        i_cmd,
    output logic        busy,
    output logic        o_res_valid,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_FM, S_V0, S_V0W, S_VT, S_VTW, S_D, S_SQ, S_DV, S_DVW,
        S_WA, S_WB, S_RD, S_PM, S_PD, S_PDW, S_PS, S_EMIT, S_ER, S_EH, S_EHW,
        S_EA, S_EO
    } t_state;

    t_state r_state;

    // configuration
    logic [9:0]  r_full_steps;
    logic [8:0]  r_microsteps;
    logic [15:0] r_min_pulses;

    // request and working registers
    t_cmd              r_cmd;
    logic [AW-1:0]     r_t;
    logic [18:0]       r_fm;
    logic [30:0]       r_rpmx;
    logic [SPD_W-1:0]  r_v0;
    logic [SPD_W-1:0]  r_vt;
    logic [24:0]       r_dmag;
    logic              r_dneg;
    logic [2*AW-1:0]   r_hh;
    logic [2*AW-1:0]   r_ii;
    logic [24:0]       r_dv;
    logic [AW-1:0]     r_i;
    logic [SPD_W-1:0]  r_prev;
    logic [46:0]       r_prod;
    logic [60:0]       r_pl;
    logic [60:0]       r_ph;
    logic [SPD_W-1:0]  r_lastp;
    logic [CW-1:0]     r_cnt;
    logic [SPD_W-1:0]  r_p;
    logic [15:0]       r_hold;
    logic [39:0]       r_add;
    logic [39:0]       r_cum;
    logic              r_res_valid;
    t_result           r_result;

    // memories
    logic [SPD_W-1:0] m_speed [TABLE_DEPTH];
    logic [SPD_W-1:0] m_level [TABLE_DEPTH];
    logic [SPD_W-1:0] r_spd_q;
    logic [SPD_W-1:0] r_lvl_q;

    logic             spd_we;
    logic [AW-1:0]    spd_waddr;
    logic [SPD_W-1:0] spd_wdata;
    logic             lvl_we;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [AW-1:0]     n_h;
    logic [26:0]       n_diff;
    logic [26:0]       n_absd;
    logic [58:0]       n_q60;
    logic [79:0]       n_psum;
    logic [SPD_W-1:0]  n_p;
    logic              n_keep;
    logic [SPD_W:0]    n_sum2;
    logic [40:0]       n_cum;
    int                n_tfull;

    sctab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_h     = r_t >> 1;
        n_diff  = {1'b0, r_vt} - {1'b0, r_v0};
        n_absd  = n_diff[26] ? 27'(-n_diff) : n_diff;
        // Steps per second: the product over 4, then times the reciprocal of 15.
        n_q60   = 59'(r_rpmx[30:2]) * 59'(RECIP_15);
        // The pulse quotient is assembled from the two partial products.
        n_psum  = 80'({r_ph, 20'd0}) + 80'(r_pl);
        n_p     = n_psum[79:54];
        n_keep  = (n_p != '0) && ((r_cnt == '0) || (n_p != r_lastp));
        n_sum2  = {1'b0, r_spd_q} + {1'b0, ((r_i == '0) ? r_spd_q : r_prev)};
        n_cum   = {1'b0, r_cum} + {1'b0, r_add};
        n_tfull = int'(i_cmd.ramp_intervals);
    end

    // Divider requests, one per issue state.
    always_comb begin
        div_req = '0;
        case (r_state)
            S_DV: begin
                div_req.start    = (r_hh != '0);
                div_req.dividend = DIV_NW'(r_dmag) * DIV_NW'(r_ii);
                div_req.divisor  = DIV_DW'(r_hh);
            end
            S_EH: begin
                div_req.start    = (r_lvl_q < SPD_W'(r_min_pulses));
                div_req.dividend = DIV_NW'(r_min_pulses);
                div_req.divisor  = r_lvl_q;
            end
            default: div_req = '0;
        endcase
    end

    // Speed memory write: the low half of the curve first, then the mirrored
    // point, so the mirrored value wins where both fall on one entry.
    always_comb begin
        spd_we    = (r_state == S_WA) || (r_state == S_WB);
        spd_waddr = (r_state == S_WA) ? r_i : AW'(r_t - r_i);
        if (r_state == S_WA) begin
            spd_wdata = r_dneg ? SPD_W'(r_v0 - r_dv) : SPD_W'(r_v0 + r_dv);
        end else begin
            spd_wdata = r_dneg ? SPD_W'(r_vt + r_dv) : SPD_W'(r_vt - r_dv);
        end
        lvl_we = (r_state == S_PS) && n_keep;
    end

    always_ff @(posedge i_clk) begin
        if (spd_we) begin
            m_speed[spd_waddr] <= spd_wdata;
        end
        r_spd_q <= m_speed[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            m_level[r_cnt[AW-1:0]] <= n_p;
        end
        r_lvl_q <= m_level[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_steps <= 10'd200;
            r_microsteps <= 9'd1;
            r_min_pulses <= 16'd50;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FULL_STEPS: r_full_steps <= i_cfg_wdata[9:0];
                CFG_MICROSTEPS: r_microsteps <= i_cfg_wdata[8:0];
                CFG_MIN_PULSES: r_min_pulses <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start && (i_cmd.cmd == CMD_RAMP)) begin
                        r_cmd   <= i_cmd;
                        r_t     <= (n_tfull > TABLE_DEPTH - 1) ? AW'(TABLE_DEPTH - 1)
                                                               : AW'(n_tfull);
                        r_state <= S_FM;
                    end
                end
                S_FM: begin
                    r_fm    <= r_full_steps * r_microsteps;
                    r_state <= S_V0;
                end
                S_V0: begin
                    r_rpmx  <= 31'(r_cmd.start_rpm) * 31'(r_fm);
                    r_state <= S_V0W;
                end
                S_V0W: begin
                    r_v0    <= n_q60[58:33];
                    r_state <= S_VT;
                end
                S_VT: begin
                    r_rpmx  <= 31'(r_cmd.end_rpm) * 31'(r_fm);
                    r_state <= S_VTW;
                end
                S_VTW: begin
                    r_vt    <= n_q60[58:33];
                    r_state <= S_D;
                end
                S_D: begin
                    // Half the difference, truncated toward zero.
                    r_dmag  <= n_absd[25:1];
                    r_dneg  <= n_diff[26];
                    r_hh    <= n_h * n_h;
                    r_i     <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_ii    <= r_i * r_i;
                    r_state <= S_DV;
                end
                S_DV: begin
                    if (r_hh == '0) begin
                        r_dv    <= '0;
                        r_state <= S_WA;
                    end else begin
                        r_state <= S_DVW;
                    end
                end
                S_DVW: begin
                    if (div_rsp.done) begin
                        r_dv    <= div_rsp.quot[24:0];
                        r_state <= S_WA;
                    end
                end
                S_WA: r_state <= S_WB;
                S_WB: begin
                    if (r_i == n_h) begin
                        r_i     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_SQ;
                    end
                end
                S_RD: r_state <= S_PM;
                S_PM: begin
                    r_prod  <= 47'(n_sum2) * 47'(r_cmd.interval_us);
                    r_prev  <= r_spd_q;
                    r_state <= S_PD;
                end
                S_PD: begin
                    r_pl    <= 61'(r_prod[26:7]) * 61'(RECIP_15625);
                    r_state <= S_PDW;
                end
                S_PDW: begin
                    r_ph    <= 61'(r_prod[46:27]) * 61'(RECIP_15625);
                    r_state <= S_PS;
                end
                S_PS: begin
                    if (n_keep) begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_lastp <= n_p;
                    end
                    if (r_i == r_t) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_RD;
                    end
                end
                S_EMIT: begin
                    r_i   <= '0;
                    r_cum <= '0;
                    if (r_cnt == '0) begin
                        r_result    <= t_result'{level_index: '0, pulses_per_interval: '0,
                                                 hold_intervals: '0, cumulative_pulses: '0,
                                                 empty_res: 1'b1, last: 1'b1};
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_ER;
                    end
                end
                S_ER: r_state <= S_EH;
                S_EH: begin
                    r_p <= r_lvl_q;
                    if (r_lvl_q < SPD_W'(r_min_pulses)) begin
                        r_state <= S_EHW;
                    end else begin
                        r_hold  <= '0;
                        r_state <= S_EA;
                    end
                end
                S_EHW: begin
                    if (div_rsp.done) begin
                        // Ceiling: round up when anything is left over.
                        r_hold  <= div_rsp.quot[15:0] + 16'(div_rsp.rem != '0);
                        r_state <= S_EA;
                    end
                end
                S_EA: begin
                    r_add   <= (r_hold != '0) ? 40'(r_hold) * 40'(r_p) : 40'(r_p);
                    r_state <= S_EO;
                end
                S_EO: begin
                    r_cum <= n_cum[40] ? '1 : n_cum[39:0];
                    r_result.level_index         <= 6'(r_i);
                    r_result.pulses_per_interval <= 32'(r_p);
                    r_result.hold_intervals      <= r_hold;
                    r_result.cumulative_pulses   <= n_cum[40] ? '1 : n_cum[39:0];
                    r_result.empty_res           <= 1'b0;
                    r_result.last                <= (CW'(r_i) + CW'(1) == r_cnt);
                    r_res_valid                  <= 1'b1;
                    if (CW'(r_i) + CW'(1) == r_cnt) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_ER;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for s_curve_step_ramp_table: directed and random ramp requests.
// Each word is checked against a built-in predictor. Depends on sctab_pkg and the design.
module tb_top;
    import sctab_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_cmd        i_cmd;
    logic        busy;
    logic        o_res_valid;
    t_result     o_result;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_wdata;

    // Register copies as the block should hold them.
    logic [9:0]  full_steps_q;
    logic [8:0]  microsteps_q;
    logic [15:0] min_pulses_q;

    t_result     level_words_q[$];
    int          mismatches;
    int          sender_idle_pct;
    int          quiet_cycles;

    s_curve_step_ramp_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Works out the level words that one command word should give.
    function automatic void predict_levels(t_cmd c);
        longint            v0, vt, d, hh, dv;
        longint unsigned   spd[64];
        longint unsigned   lvl[64];
        longint unsigned   a, b, p, hold, cum;
        int                t, h, cnt;
        t_result           r;
        if (c.cmd != CMD_RAMP) return;
        v0 = longint'((64'(c.start_rpm) * full_steps_q * microsteps_q) / 60);
        vt = longint'((64'(c.end_rpm) * full_steps_q * microsteps_q) / 60);
        t  = c.ramp_intervals;
        h  = t / 2;
        d  = (vt - v0) / 2;
        hh = longint'(h * h);
        for (int i = 0; i <= h; i++) begin
            dv = 0;
            if (hh != 0) dv = (d * longint'(i * i)) / hh;
            spd[i]     = longint'(v0 + dv) & 64'h3FF_FFFF;
            spd[t - i] = longint'(vt - dv) & 64'h3FF_FFFF;
        end
        cnt = 0;
        for (int i = 0; i <= t; i++) begin
            a = spd[i];
            b = (i == 0) ? a : spd[i - 1];
            p = ((a + b) * c.interval_us) / 2000000;
            if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
            if (p == 0) continue;
            if (cnt == 0 || lvl[cnt - 1] != p) begin
                lvl[cnt] = p;
                cnt++;
            end
        end
        if (cnt == 0) begin
            r = '0;
            r.empty_res = 1'b1;
            r.last = 1'b1;
            level_words_q.push_back(r);
            return;
        end
        cum = 0;
        for (int i = 0; i < cnt; i++) begin
            p = lvl[i];
            hold = 0;
            if (p < min_pulses_q) hold = (min_pulses_q + p - 1) / p;
            cum += (hold != 0) ? hold * p : p;
            if (cum > 64'hFF_FFFF_FFFF) cum = 64'hFF_FFFF_FFFF;
            r.level_index         = 6'(i);
            r.pulses_per_interval = 32'(p);
            r.hold_intervals      = 16'(hold);
            r.cumulative_pulses   = 40'(cum);
            r.empty_res           = 1'b0;
            r.last                = (i + 1 == cnt);
            level_words_q.push_back(r);
        end
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Result words cannot be held off, so each one is checked on the edge it is taken.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid) begin
            if (level_words_q.size() == 0) begin
                report_mismatch("unexpected word", o_result.level_index, 0);
            end else begin
                want = level_words_q.pop_front();
                if (o_result.level_index != want.level_index)
                    report_mismatch("level_index", o_result.level_index, want.level_index);
                if (o_result.pulses_per_interval != want.pulses_per_interval)
                    report_mismatch("pulses_per_interval", o_result.pulses_per_interval,
                                    want.pulses_per_interval);
                if (o_result.hold_intervals != want.hold_intervals)
                    report_mismatch("hold_intervals", o_result.hold_intervals,
                                    want.hold_intervals);
                if (o_result.cumulative_pulses != want.cumulative_pulses)
                    report_mismatch("cumulative_pulses", o_result.cumulative_pulses,
                                    want.cumulative_pulses);
                if (o_result.empty_res != want.empty_res)
                    report_mismatch("empty_res", o_result.empty_res, want.empty_res);
                if (o_result.last != want.last)
                    report_mismatch("last", o_result.last, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Leaves start high after acceptance; callers lower it with end_burst.
    task automatic send_word(t_cmd c);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        predict_levels(c);
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // A dropped word gives no result, so allow the block time to settle as well.
    task automatic wait_idle();
        while (level_words_q.size() != 0 || busy) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Leaves the write enable high; set_regs lowers it after the last write.
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_FULL_STEPS: full_steps_q = data[9:0];
            CFG_MICROSTEPS: microsteps_q = data[8:0];
            CFG_MIN_PULSES: min_pulses_q = data;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] fs, logic [15:0] ms, logic [15:0] mp);
        write_reg(CFG_FULL_STEPS, fs);
        write_reg(CFG_MICROSTEPS, ms);
        write_reg(CFG_MIN_PULSES, mp);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cmd make_word(logic c, int s, int e, int t, int us);
        t_cmd w;
        w.cmd            = c;
        w.start_rpm      = 12'(s);
        w.end_rpm        = 12'(e);
        w.ramp_intervals = 6'(t);
        w.interval_us    = 20'(us);
        return w;
    endfunction

    function automatic t_cmd random_word();
        t_cmd w;
        int   sel;
        w.cmd = ($urandom_range(99) < 8) ? ~CMD_RAMP : CMD_RAMP;
        sel = $urandom_range(9);
        w.start_rpm = (sel == 0) ? 12'd0 : (sel == 1) ? 12'hFFF : 12'($urandom);
        sel = $urandom_range(9);
        w.end_rpm = (sel == 0) ? 12'd0 : (sel == 1) ? 12'hFFF : 12'($urandom);
        // Long ramps are slow, so most requests stay short.
        w.ramp_intervals = ($urandom_range(99) < 75) ? 6'($urandom_range(12)) : 6'($urandom);
        sel = $urandom_range(9);
        w.interval_us = (sel == 0) ? 20'($urandom_range(3)) :
                        (sel < 4) ? 20'($urandom_range(20000)) : 20'($urandom);
        return w;
    endfunction

    task automatic test_special_cases();
        send_word(make_word(~CMD_RAMP, 1000, 2000, 10, 1000));
        send_word(make_word(CMD_RAMP, 0, 0, 20, 1000));
        send_word(make_word(CMD_RAMP, 300, 900, 8, 0));
        send_word(make_word(CMD_RAMP, 100, 700, 0, 5000));
        send_word(make_word(CMD_RAMP, 100, 700, 1, 5000));
        send_word(make_word(CMD_RAMP, 100, 700, 2, 5000));
        send_word(make_word(CMD_RAMP, 0, 4095, 63, 1000));
        send_word(make_word(CMD_RAMP, 4095, 0, 63, 1000));
        send_word(make_word(CMD_RAMP, 500, 500, 9, 2000));
        send_word(make_word(CMD_RAMP, 0, 60, 12, 300));
        send_word(make_word(CMD_RAMP, 4095, 4095, 5, 20'hFFFFF));
        send_word(make_word(CMD_RAMP, 1, 1, 3, 1));
        end_burst();
    endtask

    task automatic test_register_extremes();
        wait_idle();
        set_regs(16'd1023, 16'd256, 16'd0);
        send_word(make_word(CMD_RAMP, 4095, 0, 63, 20'hFFFFF));
        send_word(make_word(CMD_RAMP, 10, 4000, 17, 777));
        end_burst();
        wait_idle();
        set_regs(16'd1, 16'd1, 16'd65535);
        send_word(make_word(CMD_RAMP, 0, 4095, 30, 20'hFFFFF));
        send_word(make_word(CMD_RAMP, 4095, 4095, 4, 600000));
        end_burst();
        wait_idle();
        // A zero factor leaves every speed at zero; wider data is cut to width.
        set_regs(16'hFC00, 16'hFE00, 16'hFFFF);
        send_word(make_word(CMD_RAMP, 1234, 3000, 6, 1000));
        end_burst();
    endtask

    task automatic test_random(int n, int idle_pct);
        wait_idle();
        set_regs(16'($urandom_range(1023, 1)), 16'($urandom_range(256, 1)),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(200)));
        sender_idle_pct = idle_pct;
        for (int k = 0; k < n; k++) send_word(random_word());
        end_burst();
        sender_idle_pct = 0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_cmd           = '0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        full_steps_q    = 10'd200;
        microsteps_q    = 9'd1;
        min_pulses_q    = 16'd50;
        mismatches      = 0;
        sender_idle_pct = 0;
        quiet_cycles    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_register_extremes();
        test_random(35, 0);
        test_random(35, 46);
        test_random(35, 0);
        test_random(35, 35);

        wait_idle();
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
